// ----- sv/assert_macros.svh -----
// Assertion macros shared by the gradient magnitude RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on clk and are disabled while arst_n is low; the module
// that uses them must have signals of those names in scope.

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never hold.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ----- sv/fdgm_pkg.sv -----
// Types, constants and square root helpers of the gradient magnitude block.
package fdgm_pkg;

	// Configuration port.
	localparam int CFG_INDEX_BITS  = 1;
	localparam int CFG_DATA_BITS   = 12;
	localparam int WIDTH_REG_BITS  = 11;
	localparam int HEIGHT_REG_BITS = 12;
	localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 12'd768;
	localparam int MIN_DIM = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_index_t;

	// Datapath widths.
	localparam int ROW_BITS    = 12;
	localparam int PIX_BITS    = 8;
	localparam int DIFF_BITS   = PIX_BITS + 1;
	localparam int SQ_BITS     = 2 * PIX_BITS;
	localparam int ENERGY_BITS = SQ_BITS + 1;
	localparam int RAD_BITS    = 18;
	localparam int ROOT_BITS   = RAD_BITS / 2;
	localparam int REM_BITS    = ROOT_BITS + 3;
	localparam int SQRT_STEPS_PER_STAGE = 3;

	// Job queue between the front and the back.
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = 2;

	// One pixel's work as handed to the back.
	typedef struct packed {
		logic signed [DIFF_BITS-1:0] dv;
		logic signed [DIFF_BITS-1:0] dh;
		logic                        two_results;
		logic                        last_of_frame;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Running state of the digit-by-digit square root.
	typedef struct packed {
		logic [RAD_BITS-1:0]  rad;
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
	} sqrt_state_t;

	// One restoring step: brings in two radicand bits, yields one root bit.
	function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
		sqrt_state_t          n;
		logic [REM_BITS-1:0]  acc;
		logic [REM_BITS-1:0]  trial;
		acc   = {s.rem[REM_BITS-3:0], s.rad[RAD_BITS-1 -: 2]};
		trial = REM_BITS'({s.root, 2'b01});
		n.rad = {s.rad[RAD_BITS-3:0], 2'b00};
		if (acc >= trial) begin
			n.rem  = acc - trial;
			n.root = {s.root[ROOT_BITS-2:0], 1'b1};
		end else begin
			n.rem  = acc;
			n.root = {s.root[ROOT_BITS-2:0], 1'b0};
		end
		return n;
	endfunction

	// The steps that one pipeline stage of the root performs.
	function automatic sqrt_state_t sqrt_stage(input sqrt_state_t s);
		sqrt_state_t t;
		t = s;
		for (int i = 0; i < SQRT_STEPS_PER_STAGE; i++) begin
			t = sqrt_step(t);
		end
		return t;
	endfunction

endpackage

// ----- sv/fdgm_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module fdgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write and registered read; the read data holds until the next read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/fdgm_front.sv -----
// Front end: configuration, raster counters, line buffer and pixel classification.
module fdgm_front import fdgm_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [PIX_BITS-1:0]       pixel_value,
	output logic                      push,
	output job_t                      push_job,
	input  queue_status_t             q_status
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_BITS) ?
		$clog2(MAX_WIDTH + 1) : WIDTH_REG_BITS;

	logic [WIDTH_REG_BITS-1:0]  width_q;
	logic [HEIGHT_REG_BITS-1:0] height_q;
	logic [CW-1:0]              col_q;
	logic [ROW_BITS-1:0]        row_q;

	logic [WW-1:0]              w_ext;
	logic [WW-1:0]              w_eff;
	logic [WW-1:0]              col_ext;
	logic [HEIGHT_REG_BITS-1:0] h_eff;
	logic                       row_end;
	logic                       last_row;
	logic                       compute;
	logic                       accept;
	logic                       drain;
	logic [CW-1:0]              rd_addr;
	logic [PIX_BITS-1:0]        right_pix;

	logic                       valid_s1;
	logic [PIX_BITS-1:0]        pixel_s1;
	logic [PIX_BITS-1:0]        centre_s1;
	logic                       emit_s1;
	logic                       compute_s1;
	logic                       two_s1;
	logic                       last_s1;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_REG_BITS-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Effective image size: width clamped to the line buffer, both at least three.
	always_comb begin
		w_ext = WW'(width_q);
		if (w_ext < WW'(MIN_DIM)) begin
			w_eff = WW'(MIN_DIM);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		h_eff = (height_q < HEIGHT_REG_BITS'(MIN_DIM)) ? HEIGHT_REG_BITS'(MIN_DIM) : height_q;
	end

	// Position classification of the arriving pixel.
	assign col_ext  = WW'(col_q);
	assign row_end  = col_ext >= (w_eff - WW'(1));
	assign last_row = row_q >= (h_eff - HEIGHT_REG_BITS'(1));
	assign compute  = (row_q >= ROW_BITS'(2)) && (col_q != '0) &&
		(col_ext <= (w_eff - WW'(2)));

	// A pixel enters when stage one is empty or can hand its work on.
	assign drain    = valid_s1 && !q_status.full;
	assign in_stall = valid_s1 && q_status.full;
	assign accept   = in_valid && !in_stall;

	// The right-hand neighbour of the row above is fetched as the pixel enters.
	assign rd_addr = (col_q == CW'(MAX_WIDTH - 1)) ? '0 : col_q + CW'(1);

	fdgm_ram #(
		.WIDTH(PIX_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(col_q),
		.wr_data(pixel_value),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(right_pix)
	);

	// Raster counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage one payload. The read data still held from the previous pixel is
	// the value above this pixel.
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1   <= pixel_value;
			centre_s1  <= right_pix;
			emit_s1    <= row_q != '0;
			compute_s1 <= compute;
			two_s1     <= last_row;
			last_s1    <= last_row && row_end;
		end
	end

	// Differences go to the queue; border positions carry zero differences.
	always_comb begin
		push = drain && emit_s1;
		if (compute_s1) begin
			push_job.dv = $signed({1'b0, pixel_s1}) - $signed({1'b0, centre_s1});
			push_job.dh = $signed({1'b0, right_pix}) - $signed({1'b0, centre_s1});
		end else begin
			push_job.dv = '0;
			push_job.dh = '0;
		end
		push_job.two_results   = two_s1;
		push_job.last_of_frame = last_s1;
	end

endmodule

// ----- sv/fdgm_queue.sv -----
// Short job queue that decouples the front end from the back end.
`include "assert_macros.svh"

module fdgm_queue import fdgm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  job_t          push_job,
	input  logic          pop,
	output job_t          pop_job,
	output queue_status_t q_status
);

	job_t                      mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;

	assign q_status.full  = count_q == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
	assign q_status.empty = count_q == '0;
	assign pop_job        = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_PTR_BITS + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_PTR_BITS + 1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	`ASSERT_NEVER(a_no_push_when_full, push && q_status.full, "push into a full queue")
	`ASSERT_NEVER(a_no_pop_when_empty, pop && q_status.empty, "pop from an empty queue")

endmodule

// ----- sv/fdgm_back.sv -----
// Back end: squares, pipelined square root, saturation and result output.
`include "assert_macros.svh"

module fdgm_back import fdgm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  job_t                pop_job,
	input  queue_status_t       q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [PIX_BITS-1:0] magnitude,
	output logic                last_of_frame
);

	logic                          out_free;
	logic                          advance;
	logic signed [2*DIFF_BITS-1:0] prod_v;
	logic signed [2*DIFF_BITS-1:0] prod_h;
	logic [ENERGY_BITS-1:0]        energy;
	sqrt_state_t                   root_init;

	logic                          valid_s1, valid_s2, valid_s3, valid_s4;
	logic                          two_s1, two_s2, two_s3, two_s4;
	logic                          last_s1, last_s2, last_s3, last_s4;
	logic [SQ_BITS-1:0]            sqv_s1, sqh_s1;
	sqrt_state_t                   st_s2, st_s3, st_s4;

	logic                          out_valid_q;
	logic [PIX_BITS-1:0]           magnitude_q;
	logic                          last_q;
	logic                          second_q;
	logic                          second_last_q;

	// The pipeline moves when the output register can load a first result.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = out_free && !second_q;
	assign pop      = advance && !q_status.empty;

	// Squares of the differences; each fits in sixteen bits.
	assign prod_v = pop_job.dv * pop_job.dv;
	assign prod_h = pop_job.dh * pop_job.dh;

	// Energy and the root's starting state.
	always_comb begin
		energy         = ENERGY_BITS'(sqv_s1) + ENERGY_BITS'(sqh_s1);
		root_init.rad  = RAD_BITS'(energy);
		root_init.rem  = '0;
		root_init.root = '0;
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= !q_status.empty;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage payloads: squares, then three root stages of three steps each.
	always_ff @(posedge clk) begin
		if (advance) begin
			sqv_s1  <= prod_v[SQ_BITS-1:0];
			sqh_s1  <= prod_h[SQ_BITS-1:0];
			two_s1  <= pop_job.two_results;
			last_s1 <= pop_job.last_of_frame;
			st_s2   <= sqrt_stage(root_init);
			two_s2  <= two_s1;
			last_s2 <= last_s1;
			st_s3   <= sqrt_stage(st_s2);
			two_s3  <= two_s2;
			last_s3 <= last_s2;
			st_s4   <= sqrt_stage(st_s3);
			two_s4  <= two_s3;
			last_s4 <= last_s3;
		end
	end

	// Output register; a last-row pixel adds a zero border result after its first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (out_free) begin
			if (second_q) begin
				out_valid_q <= 1'b1;
				second_q    <= 1'b0;
			end else begin
				out_valid_q <= valid_s4;
				second_q    <= valid_s4 && two_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (second_q) begin
				magnitude_q <= '0;
				last_q      <= second_last_q;
			end else begin
				magnitude_q   <= st_s4.root[ROOT_BITS-1] ? '1 : st_s4.root[PIX_BITS-1:0];
				last_q        <= 1'b0;
				second_last_q <= last_s4;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign magnitude     = magnitude_q;
	assign last_of_frame = last_q;

	`ASSERT_IMPLIES(a_second_behind_first, second_q, out_valid_q,
		"border result pending without a first result on the output")
	`ASSERT_IMPLIES(a_last_is_border, out_valid_q && last_q, magnitude_q == '0,
		"final result of the frame is not a zero border result")

endmodule

// ----- sv/forward_difference_gradient_magnitude.sv -----
// Top level of the streaming forward-difference gradient magnitude block.
// Pixels arrive in raster order, one per clock when neither side stalls; the
// result for a position appears as the pixel one row below it arrives, and
// every pixel of the last row adds a zero border result, so a frame of H rows
// gives H*W results and the final one carries last_of_frame. The input takes
// one pixel per cycle unless in_stall is high and the output port delivers one
// result per cycle unless out_stall is high, so the last row, which gives two
// results per pixel, stalls the input once the four-entry job queue has
// filled. A pixel's first result passes through the classification stage, the
// queue, the squaring and square root stages and the output register. The line
// buffer is a RAM of MAX_WIDTH entries that needs no clearing pass.
module forward_difference_gradient_magnitude import fdgm_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [PIX_BITS-1:0]       pixel_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [PIX_BITS-1:0]       magnitude,
	output logic                      last_of_frame
);

	logic          push;
	logic          pop;
	job_t          push_job;
	job_t          pop_job;
	queue_status_t q_status;

	// Front end: counters, line buffer and difference forming.
	fdgm_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_value(pixel_value),
		.push       (push),
		.push_job   (push_job),
		.q_status   (q_status)
	);

	// Job queue between the two halves.
	fdgm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.pop_job (pop_job),
		.q_status(q_status)
	);

	// Back end: magnitude and result output.
	fdgm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_job      (pop_job),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.magnitude    (magnitude),
		.last_of_frame(last_of_frame)
	);

endmodule
